// ===== sv/depth_pixel_compositor_macros.svh =====
// assertion helpers of the compositor rtl
`ifndef DEPTH_PIXEL_COMPOSITOR_MACROS_SVH
`define DEPTH_PIXEL_COMPOSITOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define DPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpc same-cycle check failed");

// next-cycle implication, checked out of reset
`define DPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpc next-cycle check failed");

`endif

// ===== sv/dpc_pkg.sv =====
// ----------------------------------------------------------------------------
// dpc_pkg
// shared widths, types and mode codes of the depth pixel compositor
// ----------------------------------------------------------------------------
package dpc_pkg;

    localparam int CH_W           = 8;
    localparam int DEPTH_FIELD_W  = 24;
    localparam int DEPTH_BITS_DEF = 24;
    localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};

    typedef logic [CH_W-1:0] ch_t;

    // premultiplied rgba pixel colour
    typedef struct packed {
        ch_t red;
        ch_t green;
        ch_t blue;
        ch_t alpha;
    } rgba_t;

    // merge mode register codes
    typedef enum logic {
        MODE_MIN_DEPTH = 1'b0,
        MODE_BLEND     = 1'b1
    } mode_t;

endpackage

// ===== sv/dpc_over_channel.sv =====
// ----------------------------------------------------------------------------
// dpc_over_channel
// one channel of premultiplied over: near + floor((255 - alpha) * far / 255),
// saturated at full scale
// ----------------------------------------------------------------------------
module dpc_over_channel (
    input  dpc_pkg::ch_t near_val,
    input  dpc_pkg::ch_t far_val,
    input  dpc_pkg::ch_t alpha_near,
    output dpc_pkg::ch_t result
);
    import dpc_pkg::*;

    logic [CH_W-1:0]   inv_alpha;
    logic [2*CH_W-1:0] prod;
    logic [2*CH_W-1:0] acc;
    logic [CH_W-1:0]   quot;
    logic [CH_W:0]     sum;

    // weight of the far pixel
    assign inv_alpha = CH_MAX - alpha_near;
    assign prod      = {{CH_W{1'b0}}, inv_alpha} * {{CH_W{1'b0}}, far_val};

    // exact floor divide by 255 for products up to 255*255: (x + (x >> 8) + 1) >> 8
    assign acc  = prod + {{CH_W{1'b0}}, prod[2*CH_W-1:CH_W]} + {{(2*CH_W-1){1'b0}}, 1'b1};
    assign quot = acc[2*CH_W-1:CH_W];

    // add and clamp
    assign sum    = {1'b0, near_val} + {1'b0, quot};
    assign result = sum[CH_W] ? CH_MAX : sum[CH_W-1:0];

endmodule

// ===== sv/dpc_merge.sv =====
// ----------------------------------------------------------------------------
// dpc_merge
// depth test and colour merge of one pixel pair
// ----------------------------------------------------------------------------
module dpc_merge #(
    parameter int DEPTH_BITS = dpc_pkg::DEPTH_BITS_DEF
) (
    input  dpc_pkg::mode_t   mode,
    input  logic [DEPTH_BITS-1:0] depth_a,
    input  dpc_pkg::rgba_t   color_a,
    input  logic [DEPTH_BITS-1:0] depth_b,
    input  dpc_pkg::rgba_t   color_b,
    output logic [DEPTH_BITS-1:0] depth_near,
    output dpc_pkg::rgba_t   color_out
);
    import dpc_pkg::*;

    logic  b_near;
    rgba_t near_c;
    rgba_t far_c;
    rgba_t blend_c;

    // b wins only when strictly nearer, ties keep a
    assign b_near     = depth_b < depth_a;
    assign near_c     = b_near ? color_b : color_a;
    assign far_c      = b_near ? color_a : color_b;
    assign depth_near = b_near ? depth_b : depth_a;

    // over operator on all four channels, alpha included
    dpc_over_channel u_red (
        .near_val   (near_c.red),
        .far_val    (far_c.red),
        .alpha_near (near_c.alpha),
        .result     (blend_c.red)
    );

    dpc_over_channel u_green (
        .near_val   (near_c.green),
        .far_val    (far_c.green),
        .alpha_near (near_c.alpha),
        .result     (blend_c.green)
    );

    dpc_over_channel u_blue (
        .near_val   (near_c.blue),
        .far_val    (far_c.blue),
        .alpha_near (near_c.alpha),
        .result     (blend_c.blue)
    );

    dpc_over_channel u_alpha (
        .near_val   (near_c.alpha),
        .far_val    (far_c.alpha),
        .alpha_near (near_c.alpha),
        .result     (blend_c.alpha)
    );

    // mode select
    always_comb
    begin
        case (mode)
            MODE_BLEND:     color_out = blend_c;
            MODE_MIN_DEPTH: color_out = near_c;
            default:        color_out = near_c;
        endcase
    end

endmodule

// ===== sv/depth_pixel_compositor.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_compositor
// merges a pixel of an accumulated frame with the same pixel of another frame,
// by minimum depth or by premultiplied over blending of the nearer pixel
//
//   channel   signals                        direction   transfer when
//   in        in_valid / in_stall, a+b pix   into block  in_valid & !in_stall
//   out       out_valid / out_stall, result  out of block out_valid & !out_stall
//   cfg       cfg_valid / cfg_ready, mode    into block  cfg_valid & cfg_ready
//
// one pixel pair per clock sustained while out_stall is low; an input transfer
// reaches result valid through the input register, then the result register
// the path between the registers is one 8x8 multiply per channel plus adds
// rst_n clears both stage valid flags and the mode register (min depth)
// out_stall holds the result register; in_stall rises only when both stages
// are full and the result cannot leave
// ----------------------------------------------------------------------------
module depth_pixel_compositor #(
    parameter int DEPTH_BITS = dpc_pkg::DEPTH_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,

    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic blend_mode,

    input  logic in_valid,
    output logic in_stall,
    input  logic [dpc_pkg::DEPTH_FIELD_W-1:0] depth_a,
    input  dpc_pkg::ch_t red_a,
    input  dpc_pkg::ch_t green_a,
    input  dpc_pkg::ch_t blue_a,
    input  dpc_pkg::ch_t alpha_a,
    input  logic [dpc_pkg::DEPTH_FIELD_W-1:0] depth_b,
    input  dpc_pkg::ch_t red_b,
    input  dpc_pkg::ch_t green_b,
    input  dpc_pkg::ch_t blue_b,
    input  dpc_pkg::ch_t alpha_b,

    output logic out_valid,
    input  logic out_stall,
    output logic [dpc_pkg::DEPTH_FIELD_W-1:0] depth_out,
    output dpc_pkg::ch_t red_out,
    output dpc_pkg::ch_t green_out,
    output dpc_pkg::ch_t blue_out,
    output dpc_pkg::ch_t alpha_out
);
    import dpc_pkg::*;

    `include "depth_pixel_compositor_macros.svh"

    mode_t mode_reg;

    logic                  s1_valid_reg;
    logic [DEPTH_BITS-1:0] s1_depth_a_reg;
    logic [DEPTH_BITS-1:0] s1_depth_b_reg;
    rgba_t                 s1_color_a_reg;
    rgba_t                 s1_color_b_reg;

    logic                  s2_valid_reg;
    logic [DEPTH_BITS-1:0] s2_depth_reg;
    rgba_t                 s2_color_reg;

    logic                  s2_load;
    logic                  s1_load;
    logic [DEPTH_BITS-1:0] m_depth;
    rgba_t                 m_color;

    // configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_MIN_DEPTH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= mode_t'(blend_mode);
        end
    end

    // stage handshake
    assign s2_load  = s1_valid_reg && (!s2_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && s2_valid_reg && out_stall;
    assign s1_load  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load || s2_load)
            begin
                s1_valid_reg <= s1_load;
            end
            if (s2_load || !out_stall)
            begin
                s2_valid_reg <= s2_load;
            end
        end
    end

    // input register, depths trimmed or widened to the compare width
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_depth_a_reg <= DEPTH_BITS'(depth_a);
            s1_depth_b_reg <= DEPTH_BITS'(depth_b);
            s1_color_a_reg <= '{red: red_a, green: green_a, blue: blue_a, alpha: alpha_a};
            s1_color_b_reg <= '{red: red_b, green: green_b, blue: blue_b, alpha: alpha_b};
        end
    end

    // depth test and blend
    dpc_merge #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_merge (
        .mode       (mode_reg),
        .depth_a    (s1_depth_a_reg),
        .color_a    (s1_color_a_reg),
        .depth_b    (s1_depth_b_reg),
        .color_b    (s1_color_b_reg),
        .depth_near (m_depth),
        .color_out  (m_color)
    );

    // result register
    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_depth_reg <= m_depth;
            s2_color_reg <= m_color;
        end
    end

    assign out_valid = s2_valid_reg;
    assign depth_out = DEPTH_FIELD_W'(s2_depth_reg);
    assign red_out   = s2_color_reg.red;
    assign green_out = s2_color_reg.green;
    assign blue_out  = s2_color_reg.blue;
    assign alpha_out = s2_color_reg.alpha;

    // checks
    `DPC_ASSERT_IMPL(a_stall_needs_item, clk, rst_n, in_stall, s1_valid_reg && s2_valid_reg)
    `DPC_ASSERT_NEXT(a_advance_fills_out, clk, rst_n, s2_load, s2_valid_reg)
    `DPC_ASSERT_IMPL(a_near_depth, clk, rst_n, s1_valid_reg,
        (m_depth <= s1_depth_a_reg) && (m_depth <= s1_depth_b_reg))
    `DPC_ASSERT_IMPL(a_min_mode_copies, clk, rst_n, s1_valid_reg && (mode_reg == MODE_MIN_DEPTH),
        (m_color == s1_color_a_reg) || (m_color == s1_color_b_reg))

endmodule
